>>> src/epx_pkg.sv
// ----------------------------------------------------------------------------
// epx_pkg: shared types and constants of the EPX 2x upscaler
// Pixel widths, register indexes, the per-column operand record and the
// result record that travels from the block logic to the output queue.
// ----------------------------------------------------------------------------
package epx_pkg;

  // RGB565 pixel and blend mask (clears the low bit of every channel).
  localparam int PIX_W = 16;
  localparam logic [PIX_W-1:0] BLEND_MASK = 16'hF7DE;

  // Configuration register file.
  localparam int RW_W        = 11;
  localparam int CFG_DATA_W  = RW_W;
  localparam int CFG_IDX_W   = 1;
  localparam logic [RW_W-1:0] ROW_WIDTH_RESET = 11'd256;
  localparam int MAX_ROW_WIDTH_DEF = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMOOTH_MODE = 1'b0,
    REG_ROW_WIDTH   = 1'b1
  } epx_reg_t;

  // Output queue depth; must be a power of two.
  localparam int OUTQ_DEPTH = 4;

  typedef logic [PIX_W-1:0] pix_t;

  // One accepted column together with the column held before it.
  typedef struct packed {
    pix_t left;      // left neighbour of the held centre pixel
    pix_t cmid;      // held centre pixel
    pix_t cup;       // held pixel above
    pix_t cdown;     // held pixel below
    pix_t up;        // new column
    pix_t mid;
    pix_t down;
    logic has_prev;  // a held column exists, its block is due now
    logic last;      // new column closes the row
    logic flast;     // frame flag of the new column
  } epx_stage_t;

  // Four pixels of one 2x2 output block.
  typedef struct packed {
    pix_t tl;
    pix_t tr;
    pix_t bl;
    pix_t br;
  } epx_quad_t;

  // One result item.
  typedef struct packed {
    epx_quad_t quad;
    logic      row_end;
    logic      frame_end;
    logic      run_last;
  } epx_result_t;

endpackage

>>> src/epx_column_if.sv
// ----------------------------------------------------------------------------
// epx_column_if: input column channel
// One source column of three RGB565 pixels plus the frame flag.
// ----------------------------------------------------------------------------
interface epx_column_if import epx_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_up;
  logic [PIX_W-1:0] pixel_mid;
  logic [PIX_W-1:0] pixel_down;
  logic             frame_last;

  modport source (output valid, pixel_up, pixel_mid, pixel_down, frame_last,
                  input ready);
  modport sink   (input valid, pixel_up, pixel_mid, pixel_down, frame_last,
                  output ready);
endinterface

>>> src/epx_block_if.sv
// ----------------------------------------------------------------------------
// epx_block_if: output block channel
// One 2x2 block of RGB565 pixels with its row and frame markers.
// ----------------------------------------------------------------------------
interface epx_block_if import epx_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_top_left;
  logic [PIX_W-1:0] out_top_right;
  logic [PIX_W-1:0] out_bottom_left;
  logic [PIX_W-1:0] out_bottom_right;
  logic             row_end;
  logic             frame_end;
  logic             run_last;

  modport source (output valid, out_top_left, out_top_right, out_bottom_left,
                  out_bottom_right, row_end, frame_end, run_last,
                  input ready);
  modport sink   (input valid, out_top_left, out_top_right, out_bottom_left,
                  out_bottom_right, row_end, frame_end, run_last,
                  output ready);
endinterface

>>> src/epx_cfg_if.sv
// ----------------------------------------------------------------------------
// epx_cfg_if: configuration write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface epx_cfg_if import epx_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/epx_2x_pixel_upscaler_rgb565_unit.sv
// ----------------------------------------------------------------------------
// epx_2x_pixel_upscaler_rgb565_unit: EPX 2x upscaler for RGB565 columns
// Flow: an accepted column is registered into the stage, then its blocks go
//   to the output queue; a row-closing column adds its own block last.
// Throughput: one column per cycle while the output queue has room; the
//   output queue absorbs the extra block at each row end, paid back by
//   the first column of the next row.
// Reset: rst clears the column position, stage and queue; smooth_mode goes
//   to 0 and row_width to 256.
// ----------------------------------------------------------------------------
module epx_2x_pixel_upscaler_rgb565_unit import epx_pkg::*; #(
  parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  epx_cfg_if.sink     cfg,
  epx_column_if.sink  column,
  epx_block_if.source block
);

  logic            smooth_mode;
  logic [RW_W-1:0] row_width;
  logic            stage_valid;
  epx_stage_t      stage;
  logic            stage_take;
  logic            room;
  pix_t            left_b;
  epx_quad_t       quad_a;
  epx_quad_t       quad_b;
  epx_result_t     res_a;
  epx_result_t     res_b;

  // Configuration register writes.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_mode <= 1'b0;
      row_width   <= ROW_WIDTH_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_SMOOTH_MODE: smooth_mode <= cfg.data[0];
        REG_ROW_WIDTH:   row_width   <= cfg.data[RW_W-1:0];
      endcase
    end
  end

  epx_front #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .column      (column),
    .row_width   (row_width),
    .stage_valid (stage_valid),
    .stage       (stage),
    .stage_take  (stage_take)
  );

  // Block of the held column, right neighbour is the new column.
  epx_block u_block_prev (
    .a      (stage.left),
    .x      (stage.cmid),
    .c      (stage.mid),
    .d      (stage.cup),
    .b      (stage.cdown),
    .smooth (smooth_mode),
    .quad   (quad_a)
  );

  // Block of a row-closing column, right neighbour is itself.
  assign left_b = stage.has_prev ? stage.cmid : stage.mid;

  epx_block u_block_last (
    .a      (left_b),
    .x      (stage.mid),
    .c      (stage.mid),
    .d      (stage.up),
    .b      (stage.down),
    .smooth (smooth_mode),
    .quad   (quad_b)
  );

  // Result records; the first queue slot gets whichever block comes first.
  always_comb begin
    res_a.quad      = quad_a;
    res_a.row_end   = 1'b0;
    res_a.frame_end = 1'b0;
    res_a.run_last  = !stage.last;
    res_b.quad      = quad_b;
    res_b.row_end   = 1'b1;
    res_b.frame_end = stage.flast;
    res_b.run_last  = 1'b1;
  end

  assign stage_take = stage_valid && room;

  epx_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .take   (stage_take),
    .push0  (stage.has_prev || stage.last),
    .push1  (stage.has_prev && stage.last),
    .entry0 (stage.has_prev ? res_a : res_b),
    .entry1 (res_b),
    .room   (room),
    .block  (block)
  );

  // A staged column leaves as soon as the queue has room.
  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    stage_valid && room |-> column.ready)
    else $error("stage held although the queue has room");

  // A column that starts a row is never also marked as closing it.
  a_stage_yields: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !stage.has_prev |-> stage.last == 1'b0)
    else $error("row start column marked as row end");

  // A block carries a frame end only where it also closes a row.
  a_frame_on_row: assert property (@(posedge clk) disable iff (rst)
    block.valid && block.frame_end |-> block.row_end && block.run_last)
    else $error("frame end outside a row end");

endmodule

>>> src/epx_block.sv
// ----------------------------------------------------------------------------
// epx_block: EPX rule for one centre pixel
// Compares the four neighbours and picks, or blends, the matching ones
// into the four pixels of the 2x2 block.
// ----------------------------------------------------------------------------
module epx_block import epx_pkg::*; (
  input  pix_t      a,       // left
  input  pix_t      x,       // centre
  input  pix_t      c,       // right
  input  pix_t      d,       // above
  input  pix_t      b,       // below
  input  logic      smooth,
  output epx_quad_t quad
);

  // Copied neighbour, or its RGB565 average with the centre pixel.
  function automatic pix_t pick(input pix_t n, input pix_t cx, input logic sm);
    pix_t avg;
    avg = (n & cx) + (((n ^ cx) & BLEND_MASK) >> 1);
    return sm ? avg : n;
  endfunction

  logic active;

  // The rule applies only where left differs from right and above from below.
  assign active = (a != c) && (b != d);

  always_comb begin
    quad.tl = x;
    quad.tr = x;
    quad.bl = x;
    quad.br = x;
    if (active) begin
      if (d == a) quad.tl = pick(d, x, smooth);
      if (c == d) quad.tr = pick(c, x, smooth);
      if (a == b) quad.bl = pick(a, x, smooth);
      if (b == c) quad.br = pick(b, x, smooth);
    end
  end

endmodule

>>> src/epx_front.sv
// ----------------------------------------------------------------------------
// epx_front: column tracking and input register
// Counts columns in the row, keeps the held column and its left
// neighbour, and registers each accepted column with the held one.
// ----------------------------------------------------------------------------
module epx_front import epx_pkg::*; #(
  parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  epx_column_if.sink       column,
  input  logic [RW_W-1:0]  row_width,
  output logic             stage_valid,
  output epx_stage_t       stage,
  input  logic             stage_take
);

  localparam int CNT_W  = (MAX_ROW_WIDTH > 2) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam int MAXB_W = $clog2(MAX_ROW_WIDTH + 1);
  localparam int CMP_W  = ((RW_W > MAXB_W) ? RW_W : MAXB_W) + 1;

  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] column_count_next;
  pix_t             left_mid;
  pix_t             centre_mid;
  pix_t             centre_up;
  pix_t             centre_down;
  logic [CMP_W-1:0] width_raw;
  logic [CMP_W-1:0] width_eff;
  logic             last;
  logic             first;
  logic             accept;

  assign accept       = column.valid && column.ready;
  assign column.ready = !stage_valid || stage_take;

  // Effective row width, clamped into the supported range.
  always_comb begin
    width_raw = CMP_W'(row_width);
    if (width_raw < CMP_W'(2)) begin
      width_eff = CMP_W'(2);
    end else if (width_raw > CMP_W'(MAX_ROW_WIDTH)) begin
      width_eff = CMP_W'(MAX_ROW_WIDTH);
    end else begin
      width_eff = width_raw;
    end
  end

  assign first = (column_count == '0);
  assign last  = (CMP_W'(column_count) + CMP_W'(1)) >= width_eff;
  assign column_count_next = last ? '0 : column_count + CNT_W'(1);

  // Column position and stage occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      stage_valid  <= 1'b0;
    end else begin
      if (accept) column_count <= column_count_next;
      if (accept) begin
        stage_valid <= 1'b1;
      end else if (stage_take) begin
        stage_valid <= 1'b0;
      end
    end
  end

  // Held column and the registered operands of the accepted column.
  always_ff @(posedge clk) begin
    if (accept) begin
      left_mid    <= first ? column.pixel_mid : centre_mid;
      centre_mid  <= column.pixel_mid;
      centre_up   <= column.pixel_up;
      centre_down <= column.pixel_down;

      stage.left     <= left_mid;
      stage.cmid     <= centre_mid;
      stage.cup      <= centre_up;
      stage.cdown    <= centre_down;
      stage.up       <= column.pixel_up;
      stage.mid      <= column.pixel_mid;
      stage.down     <= column.pixel_down;
      stage.has_prev <= !first;
      stage.last     <= last;
      stage.flast    <= column.frame_last;
    end
  end

  // A closing column always brings the count back to the row start.
  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> column_count == '0)
    else $error("column count did not wrap at row end");

  // Any other column advances the count by one.
  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    accept && !last |=> column_count == $past(column_count) + CNT_W'(1))
    else $error("column count did not advance");

  // The count stays inside the largest row.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(column_count) < CMP_W'(MAX_ROW_WIDTH))
    else $error("column count out of range");

endmodule

>>> src/epx_outq.sv
// ----------------------------------------------------------------------------
// epx_outq: result queue
// Takes zero, one or two results per column in one cycle and hands them
// out one per transfer, so the extra block at a row end does not stall.
// ----------------------------------------------------------------------------
module epx_outq import epx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic        push0,
  input  logic        push1,
  input  epx_result_t entry0,
  input  epx_result_t entry1,
  output logic        room,
  epx_block_if.source block
);

  localparam int PTR_W = $clog2(OUTQ_DEPTH);
  localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

  epx_result_t      mem [OUTQ_DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [1:0]       n_push;
  logic             pop;
  epx_result_t      head;

  // Room for two results regardless of the current pop.
  assign room   = count <= CNT_W'(OUTQ_DEPTH - 2);
  assign n_push = take ? ({1'b0, push0} + {1'b0, push1}) : 2'd0;
  assign pop    = block.valid && block.ready;
  assign count_next = count + CNT_W'(n_push) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count_next;
    end
  end

  // Entry storage; the second result goes right after the first.
  always_ff @(posedge clk) begin
    if (take && push0) mem[wr_ptr] <= entry0;
    if (take && push1) mem[wr_ptr + PTR_W'(1)] <= entry1;
  end

  // Head of the queue drives the output channel.
  assign head                   = mem[rd_ptr];
  assign block.valid            = count != '0;
  assign block.out_top_left     = head.quad.tl;
  assign block.out_top_right    = head.quad.tr;
  assign block.out_bottom_left  = head.quad.bl;
  assign block.out_bottom_right = head.quad.br;
  assign block.row_end          = head.row_end;
  assign block.frame_end        = head.frame_end;
  assign block.run_last         = head.run_last;

  // The queue never holds more than its depth.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(OUTQ_DEPTH))
    else $error("result queue overflow");

  // A second result pushed without a first one must be the final one of its run.
  a_push_order: assert property (@(posedge clk) disable iff (rst)
    take && push1 && !push0 |-> entry1.run_last)
    else $error("lone second result is not the final one");

  // Fill level tracks pushes and pops exactly.
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count) + CNT_W'($past(n_push)) - CNT_W'($past(pop)))
    else $error("result queue count mismatch");

endmodule
